>>> design/uvlc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package uvlc_pkg;

    localparam int KEY_MAX         = 40;
    localparam int SHIFT_W         = 6;
    localparam int KEY_POS_W       = 6;
    localparam int KEY_WORDS       = 4;
    localparam int SHIFTS_PER_WORD = 10;
    localparam int CFG_DATA_W      = 60;
    localparam int CFG_IDX_W       = 3;
    localparam int OUTQ_DEPTH      = 4;
    localparam int OUTQ_PTR_W      = 2;
    localparam int OUTQ_CNT_W      = 3;

    localparam logic [CFG_IDX_W-1:0] REG_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LEN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY0    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY3    = 3'd5;

    localparam logic [7:0] LEAD_D0 = 8'hD0;
    localparam logic [7:0] LEAD_D1 = 8'hD1;

    localparam logic [5:0] LATIN_SIZE = 6'd26;
    localparam logic [5:0] RUS_SIZE   = 6'd33;
    localparam logic [5:0] SHIFT_MAX  = 6'd32;
    localparam logic [5:0] RUS_YO_IDX = 6'd6;

    typedef logic [SHIFT_W-1:0] t_shift;
    typedef t_shift [KEY_MAX-1:0] t_key_tab;

    typedef struct packed {
        logic [KEY_POS_W-1:0] key_pos;
        logic [1:0]           cont_left;
        logic                 lead_held;
        logic                 held_d1;
    } t_state;

    typedef struct packed {
        logic [1:0] n;
        logic [7:0] b0;
        logic [7:0] b1;
    } t_res;

    typedef struct packed {
        logic       valid;
        logic [5:0] idx;
        logic       upper;
    } t_rus_hit;

    // Reduce a value below three times the modulus.
    function automatic logic [5:0] mod_small(input logic [6:0] t, input logic [5:0] m);
        logic [6:0] m1;
        logic [6:0] m2;
        m1 = {1'b0, m};
        m2 = {m, 1'b0};
        if (t >= m2) begin
            return 6'(t - m2);
        end else if (t >= m1) begin
            return 6'(t - m1);
        end else begin
            return t[5:0];
        end
    endfunction

    function automatic logic [5:0] apply_shift(input logic [5:0] idx, input logic [5:0] m,
                                               input logic [5:0] s, input logic dec);
        logic [6:0] t;
        if (dec) begin
            t = {1'b0, idx} + {m, 1'b0} - {1'b0, s};
        end else begin
            t = {1'b0, idx} + {1'b0, s};
        end
        return mod_small(t, m);
    endfunction

    function automatic t_rus_hit rus_index(input logic d1, input logic [7:0] b);
        t_rus_hit h;
        h = '{valid: 1'b0, idx: 6'd0, upper: 1'b0};
        if (!d1) begin
            if (b == 8'h81) begin
                h = '{valid: 1'b1, idx: RUS_YO_IDX, upper: 1'b1};
            end else if (b inside {[8'h90:8'h95]}) begin
                h = '{valid: 1'b1, idx: 6'(b - 8'h90), upper: 1'b1};
            end else if (b inside {[8'h96:8'hAF]}) begin
                h = '{valid: 1'b1, idx: 6'(b - 8'h8F), upper: 1'b1};
            end else if (b inside {[8'hB0:8'hB5]}) begin
                h = '{valid: 1'b1, idx: 6'(b - 8'hB0), upper: 1'b0};
            end else if (b inside {[8'hB6:8'hBF]}) begin
                h = '{valid: 1'b1, idx: 6'(b - 8'hAF), upper: 1'b0};
            end
        end else begin
            if (b inside {[8'h80:8'h8F]}) begin
                h = '{valid: 1'b1, idx: 6'(b - 8'h6F), upper: 1'b0};
            end else if (b == 8'h91) begin
                h = '{valid: 1'b1, idx: RUS_YO_IDX, upper: 1'b0};
            end
        end
        return h;
    endfunction

    function automatic logic [10:0] rus_code(input logic [5:0] k, input logic upper);
        logic [10:0] base;
        base = upper ? 11'h410 : 11'h430;
        if (k == RUS_YO_IDX) begin
            return upper ? 11'h401 : 11'h451;
        end else if (k < RUS_YO_IDX) begin
            return base + {5'd0, k};
        end else begin
            return base + {5'd0, k - 6'd1};
        end
    endfunction

endpackage
`default_nettype wire

>>> design/uvlc_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface uvlc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_message;
    modport source (output valid, output in_byte, output end_of_message, input ready);
    modport sink (input valid, input in_byte, input end_of_message, output ready);
endinterface

interface uvlc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;
    modport source (output valid, output out_byte, output last_of_run, input ready);
    modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

interface uvlc_cfg_if;
    import uvlc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> design/uvlc_xlat.sv
`timescale 1ns / 1ps
`default_nettype none
module uvlc_xlat (
    input  logic [7:0]                   i_byte,
    input  logic                         i_eom,
    input  uvlc_pkg::t_state             i_state,
    input  logic                         i_mode,
    input  logic [uvlc_pkg::KEY_POS_W-1:0] i_key_len,
    input  uvlc_pkg::t_key_tab           i_keys,
    output uvlc_pkg::t_res               o_res,
    output uvlc_pkg::t_state             o_state
);
    import uvlc_pkg::*;

    logic [KEY_POS_W-1:0] len;
    logic [KEY_POS_W-1:0] pos;
    logic [KEY_POS_W-1:0] pos_inc;
    logic [KEY_POS_W-1:0] pos_adv;
    t_shift               shift_raw;
    logic [5:0]           shift;
    t_rus_hit             hit;
    logic [5:0]           rus_new;
    logic [10:0]          cp;
    logic                 use_key;

    always_comb begin
        if (i_key_len == '0) begin
            len = KEY_POS_W'(1);
        end else if (i_key_len > KEY_POS_W'(KEY_MAX)) begin
            len = KEY_POS_W'(KEY_MAX);
        end else begin
            len = i_key_len;
        end
        pos       = (i_state.key_pos < len) ? i_state.key_pos : '0;
        shift_raw = i_keys[pos];
        shift     = (shift_raw > SHIFT_MAX) ? SHIFT_MAX : shift_raw;
        pos_inc   = pos + KEY_POS_W'(1);
        pos_adv   = (pos_inc >= len) ? '0 : pos_inc;
    end

    always_comb begin
        hit     = rus_index(i_state.held_d1, i_byte);
        rus_new = apply_shift(hit.idx, RUS_SIZE, shift, i_mode);
        cp      = rus_code(rus_new, hit.upper);
    end

    always_comb begin
        o_state = i_state;
        o_res   = '{n: 2'd0, b0: i_byte, b1: i_byte};
        use_key = 1'b0;
        if (i_state.lead_held) begin
            o_res.n           = 2'd2;
            o_state.lead_held = 1'b0;
            if (hit.valid) begin
                use_key  = 1'b1;
                o_res.b0 = {3'b110, cp[10:6]};
                o_res.b1 = {2'b10, cp[5:0]};
            end else begin
                o_res.b0 = i_state.held_d1 ? LEAD_D1 : LEAD_D0;
            end
        end else if (i_state.cont_left != 2'd0) begin
            o_res.n           = 2'd1;
            o_state.cont_left = i_state.cont_left - 2'd1;
        end else if (i_byte == LEAD_D0 || i_byte == LEAD_D1) begin
            if (i_eom) begin
                o_res.n = 2'd1;
            end else begin
                o_state.lead_held = 1'b1;
                o_state.held_d1   = (i_byte == LEAD_D1);
            end
        end else begin
            o_res.n = 2'd1;
            if ((i_byte & 8'hE0) == 8'hC0) begin
                o_state.cont_left = 2'd1;
            end else if ((i_byte & 8'hF0) == 8'hE0) begin
                o_state.cont_left = 2'd2;
            end else if ((i_byte & 8'hF8) == 8'hF0) begin
                o_state.cont_left = 2'd3;
            end
            if (i_byte inside {[8'h41:8'h5A]}) begin
                use_key  = 1'b1;
                o_res.b0 = 8'h41 + {2'b00, apply_shift(6'(i_byte - 8'h41), LATIN_SIZE,
                                                       shift, i_mode)};
            end else if (i_byte inside {[8'h61:8'h7A]}) begin
                use_key  = 1'b1;
                o_res.b0 = 8'h61 + {2'b00, apply_shift(6'(i_byte - 8'h61), LATIN_SIZE,
                                                       shift, i_mode)};
            end
        end
        if (use_key) begin
            o_state.key_pos = pos_adv;
        end
        // End of message cuts off any open group and restarts the key
        if (i_eom) begin
            o_state.key_pos   = '0;
            o_state.cont_left = 2'd0;
            o_state.lead_held = 1'b0;
        end
    end
endmodule
`default_nettype wire

>>> design/uvlc_outq.sv
`timescale 1ns / 1ps
`default_nettype none
module uvlc_outq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  uvlc_pkg::t_res   i_res,
    output logic             o_room,
    uvlc_out_if.source       o_out
);
    import uvlc_pkg::*;

    logic [OUTQ_DEPTH-1:0][7:0] r_byte;
    logic [OUTQ_DEPTH-1:0]      r_last;
    logic [OUTQ_PTR_W-1:0]      r_wr_ptr;
    logic [OUTQ_PTR_W-1:0]      n_wr_ptr;
    logic [OUTQ_PTR_W-1:0]      r_rd_ptr;
    logic [OUTQ_PTR_W-1:0]      n_rd_ptr;
    logic [OUTQ_CNT_W-1:0]      r_count;
    logic [OUTQ_CNT_W-1:0]      n_count;
    logic [OUTQ_PTR_W-1:0]      wr_ptr_1;
    logic [1:0]                 push_n;
    logic                       pop;

    assign o_room         = (r_count <= OUTQ_CNT_W'(OUTQ_DEPTH - 2));
    assign o_out.valid    = (r_count != '0);
    assign o_out.out_byte = r_byte[r_rd_ptr];
    assign o_out.last_of_run = r_last[r_rd_ptr];

    always_comb begin
        pop      = o_out.valid && o_out.ready;
        push_n   = i_push ? i_res.n : 2'd0;
        wr_ptr_1 = r_wr_ptr + OUTQ_PTR_W'(1);
        n_wr_ptr = r_wr_ptr + OUTQ_PTR_W'(push_n);
        n_rd_ptr = r_rd_ptr + OUTQ_PTR_W'(pop);
        n_count  = r_count + OUTQ_CNT_W'(push_n) - OUTQ_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_byte[r_wr_ptr] <= i_res.b0;
            r_last[r_wr_ptr] <= (push_n == 2'd1);
        end
        if (push_n == 2'd2) begin
            r_byte[wr_ptr_1] <= i_res.b1;
            r_last[wr_ptr_1] <= 1'b1;
        end
    end
endmodule
`default_nettype wire

>>> design/utf8_vigenere_latin_cyrillic.sv
`timescale 1ns / 1ps
`default_nettype none
// Vigenere cipher over a UTF-8 byte stream: Latin letters mod 26, Russian
// letters (D0/D1 pairs, YO at index 6) mod 33, everything else unchanged.
// Channels: i_in takes one byte a beat with an end_of_message flag; o_out
// gives transformed bytes, last_of_run marking the last byte a given input
// byte caused. i_cfg writes mode, key_length and four key shift words; it
// is always ready. The user must write it only while the stream is idle;
// the block does not enforce this. An accepted byte enters the output queue
// and shows on o_out after the beats ahead of it. A D0/D1 lead is held and
// gives nothing unless it ends the message; the next byte gives two beats.
// Throughput: one input byte per cycle while i_in.ready is high, set by the
// single xlat stage feeding a four-entry output queue; i_in.ready drops only
// when the queue holds more than two beats.
// Stall: when o_out.ready is low the queue fills and i_in.ready falls;
// nothing is lost or repeated.
// Reset: clears key position, grouping state, queue, and returns config to
// mode 0, key_length 1, all shifts zero.
module utf8_vigenere_latin_cyrillic (
    input  logic       i_clk,
    input  logic       i_rst_n,
    uvlc_in_if.sink    i_in,
    uvlc_out_if.source o_out,
    uvlc_cfg_if.sink   i_cfg
);
    import uvlc_pkg::*;

    logic                                  r_mode;
    logic [KEY_POS_W-1:0]                  r_key_len;
    logic [KEY_WORDS-1:0][CFG_DATA_W-1:0]  r_key_words;
    t_state                                r_state;
    t_state                                n_state;
    t_key_tab                              keys;
    t_res                                  res;
    logic                                  room;
    logic                                  in_acc;
    logic                                  cfg_acc;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = room;
    assign in_acc      = i_in.valid && room;
    assign cfg_acc     = i_cfg.valid;

    always_comb begin
        for (int i = 0; i < KEY_MAX; i++) begin
            keys[i] = r_key_words[i / SHIFTS_PER_WORD][(i % SHIFTS_PER_WORD) * SHIFT_W +: SHIFT_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= 1'b0;
            r_key_len   <= KEY_POS_W'(1);
            r_key_words <= '0;
        end else if (cfg_acc) begin
            if (i_cfg.index == REG_MODE) begin
                r_mode <= i_cfg.data[0];
            end else if (i_cfg.index == REG_KEY_LEN) begin
                r_key_len <= i_cfg.data[KEY_POS_W-1:0];
            end else if (i_cfg.index >= REG_KEY0 && i_cfg.index <= REG_KEY3) begin
                r_key_words[2'(i_cfg.index - REG_KEY0)] <= i_cfg.data;
            end
        end
    end

    uvlc_xlat u_xlat (
        .i_byte    (i_in.in_byte),
        .i_eom     (i_in.end_of_message),
        .i_state   (r_state),
        .i_mode    (r_mode),
        .i_key_len (r_key_len),
        .i_keys    (keys),
        .o_res     (res),
        .o_state   (n_state)
    );

    // Advance grouping and key state on every accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (in_acc) begin
            r_state <= n_state;
        end
    end

    uvlc_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_acc),
        .i_res   (res),
        .o_room  (room),
        .o_out   (o_out)
    );
endmodule
`default_nettype wire
